>>> rtl/hds_pkg.sv
`default_nettype none

package hds_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int TEMP_W        = 32;
   localparam int COEF_W        = 20;
   localparam int SIZE_W        = 11;
   localparam int POS_W         = 10;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MIN_SIZE      = 3;
   localparam int NUM_TERMS     = 3;
   localparam int CSR_IDX_W     = 3;

   // second differences get three bits over the temperature width
   localparam int OP_W   = TEMP_W + 3;
   localparam int PROD_W = OP_W + COEF_W + 1;
   localparam int ACC_W  = (TEMP_W + FRAC_BITS + 2 > PROD_W + 1) ?
                           (TEMP_W + FRAC_BITS + 2) : (PROD_W + 1);

   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

   localparam logic [SIZE_W-1:0]        SIZE_RESET     = SIZE_W'(1024);
   // 290.0 in Q16.16
   localparam logic signed [TEMP_W-1:0] BOUNDARY_RESET = TEMP_W'(290 * 65536);
   localparam logic signed [TEMP_W-1:0] TEMP_MAX       = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MIN       = {1'b1, {(TEMP_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH     = 3'd0,
      CSR_HEIGHT    = 3'd1,
      CSR_COEF_X    = 3'd2,
      CSR_COEF_Y    = 3'd3,
      CSR_STEP_GAIN = 3'd4,
      CSR_BOUNDARY  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             has_res;
      logic             interior;
      logic             two;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic                               valid;
      logic signed [ACC_W-1:0]            acc;
      logic [NUM_TERMS-1:0][OP_W-1:0]     ops;
      meta_type                           meta;
   } cell_bus_type;

   typedef struct packed {
      logic busy;
      logic second;
   } out_status_type;

endpackage

`default_nettype wire

>>> rtl/heat_diffusion_2d_stencil_step.sv
`default_nettype none

// One FTCS time step of a 2D temperature grid, five-point stencil, Q16.16.
// req_ channel: one grid point per word in raster order (temperature and
// heat source). rsp_ channel: next-step temperatures tagged with column and
// row; a point of row r yields the result for row r-1, points of the last
// row also yield their own border result, frame_last marks the bottom-right.
// csr_ channel: register writes, always ready; the user must write only while
// the block is idle, the block does not enforce it. Pipeline: line buffer read
// on the accepting edge, then operand stage, three multiply-accumulate cells,
// round and clamp, output register. Throughput: one word per cycle while
// rsp_ready holds; during the last row each input word yields two result words
// on the single result port, and the input is held while the second waits.
// Reset zeroes the raster counters and loads register defaults; line buffers
// are not cleared and are filled by the first two rows of a frame.
// While a result word waits on rsp_ready the whole pipeline holds and
// req_ready drops; an empty output register keeps the pipeline moving.
module heat_diffusion_2d_stencil_step #(
   parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [hds_pkg::TEMP_W-1:0]    req_temp_in,
   input  logic signed [hds_pkg::TEMP_W-1:0]    req_heat_source,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hds_pkg::TEMP_W-1:0]    rsp_temp_out,
   output logic [hds_pkg::POS_W-1:0]            rsp_col_out,
   output logic [hds_pkg::POS_W-1:0]            rsp_row_out,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hds_pkg::TEMP_W-1:0]           csr_wdata
);

   logic [hds_pkg::SIZE_W-1:0]          width_ff, height_ff;
   logic [15:0]                         coef_x_ff, coef_y_ff;
   logic [hds_pkg::COEF_W-1:0]          step_gain_ff;
   logic signed [hds_pkg::TEMP_W-1:0]   boundary_ff;

   logic                                adv;
   logic                                accept;
   hds_pkg::out_status_type             out_status;
   hds_pkg::cell_bus_type               bus [hds_pkg::NUM_TERMS+1];
   logic [hds_pkg::NUM_TERMS-1:0][hds_pkg::COEF_W-1:0] coefs;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= hds_pkg::SIZE_RESET;
         height_ff    <= hds_pkg::SIZE_RESET;
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
         step_gain_ff <= '0;
         boundary_ff  <= hds_pkg::BOUNDARY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hds_pkg::CSR_WIDTH:     width_ff     <= csr_wdata[hds_pkg::SIZE_W-1:0];
            hds_pkg::CSR_HEIGHT:    height_ff    <= csr_wdata[hds_pkg::SIZE_W-1:0];
            hds_pkg::CSR_COEF_X:    coef_x_ff    <= csr_wdata[15:0];
            hds_pkg::CSR_COEF_Y:    coef_y_ff    <= csr_wdata[15:0];
            hds_pkg::CSR_STEP_GAIN: step_gain_ff <= csr_wdata[hds_pkg::COEF_W-1:0];
            hds_pkg::CSR_BOUNDARY:  boundary_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign coefs     = {step_gain_ff, hds_pkg::COEF_W'(coef_y_ff), hds_pkg::COEF_W'(coef_x_ff)};

   hds_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .temp_in     (req_temp_in),
      .heat_source (req_heat_source),
      .width_cfg   (width_ff),
      .height_cfg  (height_ff),
      .bus_out     (bus[0])
   );

   for (genvar k = 0; k < hds_pkg::NUM_TERMS; k++) begin : g_cell
      hds_mac_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .coef    (coefs[k]),
         .bus_in  (bus[k]),
         .bus_out (bus[k+1])
      );
   end

   hds_out u_out (
      .clock          (clock),
      .reset          (reset),
      .bus_in         (bus[hds_pkg::NUM_TERMS]),
      .boundary       (boundary_ff),
      .rsp_ready      (rsp_ready),
      .adv            (adv),
      .status         (out_status),
      .rsp_valid      (rsp_valid),
      .rsp_temp_out   (rsp_temp_out),
      .rsp_col_out    (rsp_col_out),
      .rsp_row_out    (rsp_row_out),
      .rsp_frame_last (rsp_frame_last)
   );

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && out_status.second) |=> (rsp_valid && !out_status.second))
      else $error("border word of last row not presented after first word");

   a_last_on_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> !out_status.second)
      else $error("frame_last shown before the border word");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      out_status.second |-> (rsp_valid && !req_ready))
      else $error("input taken while a second word is pending");

endmodule

`default_nettype wire

>>> rtl/hds_mac_cell.sv
`default_nettype none

module hds_mac_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [hds_pkg::COEF_W-1:0]    coef,
   input  hds_pkg::cell_bus_type         bus_in,
   output hds_pkg::cell_bus_type         bus_out
);

   logic signed [hds_pkg::PROD_W-1:0] prod;
   hds_pkg::cell_bus_type             bus_ff;

   // this cell always takes the lowest operand, then shifts the rest down
   assign prod = $signed(bus_in.ops[0]) * $signed({1'b0, coef});

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (adv) begin
         bus_ff.valid <= bus_in.valid;
         bus_ff.acc   <= bus_in.acc + hds_pkg::ACC_W'(prod);
         bus_ff.ops   <= {hds_pkg::OP_W'(0), bus_in.ops[hds_pkg::NUM_TERMS-1:1]};
         bus_ff.meta  <= bus_in.meta;
      end
   end

   assign bus_out = bus_ff;

endmodule

`default_nettype wire

>>> rtl/hds_window.sv
`default_nettype none

module hds_window #(
   parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              accept,
   input  logic signed [hds_pkg::TEMP_W-1:0] temp_in,
   input  logic signed [hds_pkg::TEMP_W-1:0] heat_source,
   input  logic [hds_pkg::SIZE_W-1:0]        width_cfg,
   input  logic [hds_pkg::SIZE_W-1:0]        height_cfg,
   output hds_pkg::cell_bus_type             bus_out
);

   localparam int CNT_W = $clog2(MAX_WIDTH);
   localparam int SZ_W  = ($clog2(MAX_WIDTH + 1) > hds_pkg::SIZE_W) ?
                          $clog2(MAX_WIDTH + 1) : hds_pkg::SIZE_W;
   localparam logic [SZ_W-1:0] W_MAX = SZ_W'(MAX_WIDTH);
   localparam logic [SZ_W-1:0] W_MIN = SZ_W'(hds_pkg::MIN_SIZE);
   localparam logic [hds_pkg::SIZE_W-1:0] H_MAX = hds_pkg::SIZE_W'(hds_pkg::MAX_HEIGHT);
   localparam logic [hds_pkg::SIZE_W-1:0] H_MIN = hds_pkg::SIZE_W'(hds_pkg::MIN_SIZE);

   logic [SZ_W-1:0]             width_ext;
   logic [SZ_W-1:0]             w_eff;
   logic [hds_pkg::SIZE_W-1:0]  h_eff;

   logic [CNT_W-1:0]            col_ff, col_in;
   logic [hds_pkg::POS_W-1:0]   row_ff, row_in;
   logic                        wrap_col;
   logic [CNT_W-1:0]            cur_col;
   logic [hds_pkg::SIZE_W-1:0]  row_step;
   logic [hds_pkg::POS_W-1:0]   cur_row;
   logic [SZ_W-1:0]             col_plus;
   logic [hds_pkg::SIZE_W-1:0]  row_plus;
   logic                        end_row;
   hds_pkg::meta_type           meta_in;

   logic signed [hds_pkg::TEMP_W-1:0] older_mem  [MAX_WIDTH];
   logic signed [hds_pkg::TEMP_W-1:0] prev_t_mem [MAX_WIDTH];
   logic signed [hds_pkg::TEMP_W-1:0] prev_s_mem [MAX_WIDTH];

   logic signed [hds_pkg::TEMP_W-1:0] above_ff, right_ff, up_ff, src_ff;
   logic signed [hds_pkg::TEMP_W-1:0] cur_t_ff, cur_s_ff, left_ff;
   logic [CNT_W-1:0]                  wcol_ff;
   hds_pkg::meta_type                 meta0_ff;
   logic                              s0_valid_ff;
   logic                              wr_pend_ff;

   logic signed [hds_pkg::OP_W-1:0]   left_x, right_x, above_x, up_x, down_x, src_x;
   logic signed [hds_pkg::OP_W-1:0]   dx, dy;
   logic signed [hds_pkg::ACC_W-1:0]  acc0;
   hds_pkg::cell_bus_type             bus_ff;

   // frame size, held to the supported range
   assign width_ext = SZ_W'(width_cfg);
   always_comb begin
      priority if (width_ext < W_MIN) begin
         w_eff = W_MIN;
      end else if (width_ext > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = width_ext;
      end
      priority if (height_cfg < H_MIN) begin
         h_eff = H_MIN;
      end else if (height_cfg > H_MAX) begin
         h_eff = H_MAX;
      end else begin
         h_eff = height_cfg;
      end
   end

   // raster position of the incoming word; a count past the size ends row or frame
   assign wrap_col = SZ_W'(col_ff) >= w_eff;
   assign cur_col  = wrap_col ? '0 : col_ff;
   assign row_step = wrap_col ? hds_pkg::SIZE_W'(row_ff) + hds_pkg::SIZE_W'(1) :
                                hds_pkg::SIZE_W'(row_ff);
   assign cur_row  = (row_step >= h_eff) ? '0 : row_step[hds_pkg::POS_W-1:0];
   assign col_plus = SZ_W'(cur_col) + SZ_W'(1);
   assign row_plus = hds_pkg::SIZE_W'(cur_row) + hds_pkg::SIZE_W'(1);
   assign end_row  = col_plus >= w_eff;

   always_comb begin
      if (end_row) begin
         col_in = '0;
         row_in = (row_plus >= h_eff) ? '0 : row_plus[hds_pkg::POS_W-1:0];
      end else begin
         col_in = col_plus[CNT_W-1:0];
         row_in = cur_row;
      end
   end

   always_comb begin
      meta_in.col      = hds_pkg::POS_W'(cur_col);
      meta_in.row      = cur_row;
      meta_in.has_res  = cur_row != '0;
      meta_in.interior = (cur_row >= hds_pkg::POS_W'(2)) && (cur_col != '0) && !end_row;
      meta_in.two      = row_plus == h_eff;
      meta_in.last     = col_plus == w_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // line buffers: read on accept, written back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff <= prev_t_mem[cur_col];
         right_ff <= prev_t_mem[col_plus[CNT_W-1:0]];
         up_ff    <= older_mem[cur_col];
         src_ff   <= prev_s_mem[cur_col];
      end
      if (wr_pend_ff) begin
         older_mem[wcol_ff]  <= above_ff;
         prev_t_mem[wcol_ff] <= cur_t_ff;
         prev_s_mem[wcol_ff] <= cur_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_t_ff <= temp_in;
         cur_s_ff <= heat_source;
         wcol_ff  <= cur_col;
         meta0_ff <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         left_ff     <= '0;
      end else if (adv) begin
         s0_valid_ff <= accept;
         if (s0_valid_ff) begin
            left_ff <= above_ff;
         end
      end
   end

   // operands of the three product terms
   assign left_x  = hds_pkg::OP_W'(left_ff);
   assign right_x = hds_pkg::OP_W'(right_ff);
   assign above_x = hds_pkg::OP_W'(above_ff);
   assign up_x    = hds_pkg::OP_W'(up_ff);
   assign down_x  = hds_pkg::OP_W'(cur_t_ff);
   assign src_x   = hds_pkg::OP_W'(src_ff);
   assign dx      = left_x + right_x - (above_x <<< 1);
   assign dy      = up_x + down_x - (above_x <<< 1);
   assign acc0    = (hds_pkg::ACC_W'(above_ff) <<< hds_pkg::FRAC_BITS) + hds_pkg::HALF_LSB;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (adv) begin
         bus_ff.valid <= s0_valid_ff && meta0_ff.has_res;
         bus_ff.acc   <= acc0;
         bus_ff.ops   <= {src_x, dy, dx};
         bus_ff.meta  <= meta0_ff;
      end
   end

   assign bus_out = bus_ff;

endmodule

`default_nettype wire

>>> rtl/hds_out.sv
`default_nettype none

module hds_out (
   input  logic                              clock,
   input  logic                              reset,
   input  hds_pkg::cell_bus_type             bus_in,
   input  logic signed [hds_pkg::TEMP_W-1:0] boundary,
   input  logic                              rsp_ready,
   output logic                              adv,
   output hds_pkg::out_status_type           status,
   output logic                              rsp_valid,
   output logic signed [hds_pkg::TEMP_W-1:0] rsp_temp_out,
   output logic [hds_pkg::POS_W-1:0]         rsp_col_out,
   output logic [hds_pkg::POS_W-1:0]         rsp_row_out,
   output logic                              rsp_frame_last
);

   logic signed [hds_pkg::ACC_W-1:0]         shifted;
   logic [hds_pkg::ACC_W-hds_pkg::TEMP_W:0]  upper;
   logic signed [hds_pkg::TEMP_W-1:0]        sat;

   logic                                     rv_ff;
   logic signed [hds_pkg::TEMP_W-1:0]        rtemp_ff;
   hds_pkg::meta_type                        rmeta_ff;

   logic                                     valid_ff, two_ff, last_ff;
   logic signed [hds_pkg::TEMP_W-1:0]        temp_ff;
   logic [hds_pkg::POS_W-1:0]                col_ff, row_ff, sec_row_ff;
   logic                                     sec_last_ff;

   // floor to the output grid, then clamp to 32 bits
   assign shifted = bus_in.acc >>> hds_pkg::FRAC_BITS;
   assign upper   = shifted[hds_pkg::ACC_W-1:hds_pkg::TEMP_W-1];
   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat = shifted[hds_pkg::TEMP_W-1:0];
      end else if (shifted[hds_pkg::ACC_W-1]) begin
         sat = hds_pkg::TEMP_MIN;
      end else begin
         sat = hds_pkg::TEMP_MAX;
      end
   end

   // hold the whole pipe while the output word waits on rsp_ready or the second word of a last-row point waits
   assign adv = !valid_ff || (rsp_ready && !two_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff    <= bus_in.valid;
         rtemp_ff <= sat;
         rmeta_ff <= bus_in.meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         two_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else if (adv) begin
         valid_ff    <= rv_ff;
         two_ff      <= rv_ff && rmeta_ff.two;
         last_ff     <= 1'b0;
         temp_ff     <= rmeta_ff.interior ? rtemp_ff : boundary;
         col_ff      <= rmeta_ff.col;
         row_ff      <= rmeta_ff.row - hds_pkg::POS_W'(1);
         sec_row_ff  <= rmeta_ff.row;
         sec_last_ff <= rmeta_ff.last;
      end else if (rsp_ready && two_ff) begin
         // first word taken: present the border point of the last row
         two_ff  <= 1'b0;
         temp_ff <= boundary;
         row_ff  <= sec_row_ff;
         last_ff <= sec_last_ff;
      end
   end

   assign status.busy    = valid_ff;
   assign status.second  = two_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_temp_out   = temp_ff;
   assign rsp_col_out    = col_ff;
   assign rsp_row_out    = row_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

>>> bench/heat_diffusion_2d_stencil_step_tb.sv
`timescale 1ns / 1ps

module heat_diffusion_2d_stencil_step_tb;

   localparam int          DRAIN_CYCLES  = 16;
   localparam int unsigned RANDOM_POINTS = 1250;
   localparam int          GRID_COEF_W   = 16;
   // indexes past the last register; the block must ignore writes to them
   localparam logic [hds_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [hds_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {DATA_FULL, DATA_MILD, DATA_EXTREME} data_mix_type;

   typedef struct packed {
      logic signed [hds_pkg::TEMP_W-1:0] temp;
      logic [hds_pkg::POS_W-1:0]         col;
      logic [hds_pkg::POS_W-1:0]         row;
      logic                              last;
   } grid_point_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [hds_pkg::TEMP_W-1:0] req_temp_in = '0;
   logic signed [hds_pkg::TEMP_W-1:0] req_heat_source = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [hds_pkg::TEMP_W-1:0] rsp_temp_out;
   logic [hds_pkg::POS_W-1:0]         rsp_col_out;
   logic [hds_pkg::POS_W-1:0]         rsp_row_out;
   logic                              rsp_frame_last;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [hds_pkg::CSR_IDX_W-1:0]     csr_index = hds_pkg::CSR_WIDTH;
   logic [hds_pkg::TEMP_W-1:0]        csr_wdata = '0;

   // register shadow
   logic [hds_pkg::SIZE_W-1:0] width_reg = hds_pkg::SIZE_RESET;
   logic [hds_pkg::SIZE_W-1:0] height_reg = hds_pkg::SIZE_RESET;
   logic [GRID_COEF_W-1:0]     coef_x_reg = '0;
   logic [GRID_COEF_W-1:0]     coef_y_reg = '0;
   logic [hds_pkg::COEF_W-1:0] gain_reg = '0;
   logic [hds_pkg::TEMP_W-1:0] boundary_reg = hds_pkg::BOUNDARY_RESET;

   // grid state of the predictor
   logic [hds_pkg::TEMP_W-1:0] older_temps [hds_pkg::MAX_WIDTH_DEF];
   logic [hds_pkg::TEMP_W-1:0] above_temps [hds_pkg::MAX_WIDTH_DEF];
   logic [hds_pkg::TEMP_W-1:0] above_sources [hds_pkg::MAX_WIDTH_DEF];
   logic [hds_pkg::TEMP_W-1:0] left_of_above = '0;
   int unsigned                col_pos = 0;
   int unsigned                row_pos = 0;

   grid_point_type expected_points [$];
   grid_point_type want;
   int             mismatch_count = 0;
   int unsigned    points_sent = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   heat_diffusion_2d_stencil_step DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_temp_in    (req_temp_in),
      .req_heat_source(req_heat_source),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_temp_out   (rsp_temp_out),
      .rsp_col_out    (rsp_col_out),
      .rsp_row_out    (rsp_row_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the grid by one accepted point and queue the next-step values it yields.
   function automatic void advance_grid(input logic [hds_pkg::TEMP_W-1:0] t,
                                        input logic [hds_pkg::TEMP_W-1:0] s);
      int unsigned                w, h, c, r;
      logic [hds_pkg::TEMP_W-1:0] above, up, src_up;
      longint                     lv, cv, rv, uv, dv, acc;
      grid_point_type             res;
      w = (width_reg < hds_pkg::MIN_SIZE) ? hds_pkg::MIN_SIZE :
          (width_reg > hds_pkg::MAX_WIDTH_DEF) ? hds_pkg::MAX_WIDTH_DEF : width_reg;
      h = (height_reg < hds_pkg::MIN_SIZE) ? hds_pkg::MIN_SIZE :
          (height_reg > hds_pkg::MAX_HEIGHT) ? hds_pkg::MAX_HEIGHT : height_reg;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      above = above_temps[c];
      up = older_temps[c];
      src_up = above_sources[c];
      if (r >= 1) begin
         res.temp = boundary_reg;
         if (r >= 2 && c >= 1 && c + 1 < w) begin
            lv = longint'($signed(left_of_above));
            cv = longint'($signed(above));
            rv = longint'($signed(above_temps[c + 1]));
            uv = longint'($signed(up));
            dv = longint'($signed(t));
            // exact sum at twice the fraction bits, then round half up
            acc = (cv <<< hds_pkg::FRAC_BITS)
                + longint'(coef_x_reg) * (lv - 2 * cv + rv)
                + longint'(coef_y_reg) * (uv - 2 * cv + dv)
                + longint'(gain_reg) * longint'($signed(src_up))
                + (longint'(1) <<< (hds_pkg::FRAC_BITS - 1));
            acc = acc >>> hds_pkg::FRAC_BITS;
            if (acc > longint'(hds_pkg::TEMP_MAX)) res.temp = hds_pkg::TEMP_MAX;
            else if (acc < longint'(hds_pkg::TEMP_MIN)) res.temp = hds_pkg::TEMP_MIN;
            else res.temp = acc[hds_pkg::TEMP_W-1:0];
         end
         res.col = hds_pkg::POS_W'(c);
         res.row = hds_pkg::POS_W'(r - 1);
         res.last = 1'b0;
         expected_points.push_back(res);
         // last row also emits its own border point
         if (r + 1 == h) begin
            res.temp = boundary_reg;
            res.row = hds_pkg::POS_W'(r);
            res.last = (c + 1 == w);
            expected_points.push_back(res);
         end
      end
      left_of_above = above;
      older_temps[c] = above;
      above_temps[c] = t;
      above_sources[c] = s;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic logic [hds_pkg::TEMP_W-1:0] pick_value(input data_mix_type mix);
      logic [hds_pkg::TEMP_W-1:0] r;
      r = $urandom();
      case (mix)
         DATA_MILD: return {{11{r[20]}}, r[20:0]};
         DATA_EXTREME: begin
            case ($urandom_range(4))
               0: return hds_pkg::TEMP_MAX;
               1: return hds_pkg::TEMP_MIN;
               2: return '0;
               3: return '1;
               default: return r;
            endcase
         end
         default: return r;
      endcase
   endfunction

   task automatic send_point(input logic [hds_pkg::TEMP_W-1:0] t,
                             input logic [hds_pkg::TEMP_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temp_in <= t;
      req_heat_source <= s;
      do @(posedge clock); while (!req_ready);
      points_sent++;
      advance_grid(t, s);
   endtask

   // Leaves csr_valid high so back-to-back writes need no gap.
   task automatic write_reg(input logic [hds_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hds_pkg::TEMP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         hds_pkg::CSR_WIDTH:     width_reg = data[hds_pkg::SIZE_W-1:0];
         hds_pkg::CSR_HEIGHT:    height_reg = data[hds_pkg::SIZE_W-1:0];
         hds_pkg::CSR_COEF_X:    coef_x_reg = data[GRID_COEF_W-1:0];
         hds_pkg::CSR_COEF_Y:    coef_y_reg = data[GRID_COEF_W-1:0];
         hds_pkg::CSR_STEP_GAIN: gain_reg = data[hds_pkg::COEF_W-1:0];
         hds_pkg::CSR_BOUNDARY:  boundary_reg = data;
         default: ;
      endcase
   endtask

   // Unused upper bits of each word carry noise; the block must drop them.
   task automatic load_settings(input int unsigned w, input int unsigned h,
                                input logic [GRID_COEF_W-1:0] cx,
                                input logic [GRID_COEF_W-1:0] cy,
                                input logic [hds_pkg::COEF_W-1:0] g,
                                input logic [hds_pkg::TEMP_W-1:0] b);
      write_reg(hds_pkg::CSR_WIDTH, ($urandom() & 32'hFFFF_F800) | 32'(w));
      write_reg(hds_pkg::CSR_HEIGHT, ($urandom() & 32'hFFFF_F800) | 32'(h));
      write_reg(hds_pkg::CSR_COEF_X, ($urandom() & 32'hFFFF_0000) | 32'(cx));
      write_reg(hds_pkg::CSR_COEF_Y, ($urandom() & 32'hFFFF_0000) | 32'(cy));
      write_reg(hds_pkg::CSR_STEP_GAIN, ($urandom() & 32'hFFF0_0000) | 32'(g));
      write_reg(hds_pkg::CSR_BOUNDARY, b);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Send one whole frame; the predictor returns to the origin at its end.
   task automatic run_frame(input data_mix_type mix);
      do send_point(pick_value(mix), pick_value(mix));
      while (col_pos != 0 || row_pos != 0);
      req_valid <= 1'b0;
   endtask

   // Half-LSB results: +0.5 rounds up to 1, -0.5 rounds up to 0.
   task automatic test_rounding_ties();
      wait_drained();
      load_settings(4, 3, 16'h8000, '0, '0, hds_pkg::TEMP_MIN);
      for (int i = 0; i < 12; i++)
         send_point((i == 4) ? 32'd1 : (i == 7) ? '1 : '0, '0);
      req_valid <= 1'b0;
   endtask

   // Full gains with extreme sources drive the interior to both rails.
   task automatic test_saturation();
      wait_drained();
      load_settings(4, 3, 16'hFFFF, 16'hFFFF, 20'hFFFFF, hds_pkg::TEMP_MAX);
      for (int i = 0; i < 12; i++)
         send_point((i % 2) ? hds_pkg::TEMP_MAX : hds_pkg::TEMP_MIN,
                    (i % 4 == 1) ? hds_pkg::TEMP_MAX : (i % 4 == 2) ? hds_pkg::TEMP_MIN :
                    (i % 4 == 0) ? '0 : '1);
      req_valid <= 1'b0;
   endtask

   task automatic test_spare_index();
      wait_drained();
      write_reg(CSR_SPARE_LO, $urandom());
      write_reg(CSR_SPARE_HI, $urandom());
      load_settings(5, 4, 16'($urandom()), 16'($urandom()), 20'($urandom()), $urandom());
      run_frame(DATA_MILD);
   endtask

   // Sizes below the minimum clamp up to three.
   task automatic test_size_clamp();
      int unsigned dims [3][2];
      dims = '{'{0, 0}, '{2, 1}, '{1, 2}};
      for (int i = 0; i < 3; i++) begin
         wait_drained();
         load_settings(dims[i][0], dims[i][1], 16'($urandom()), 16'($urandom()),
                       20'($urandom()), $urandom());
         run_frame(DATA_EXTREME);
      end
   endtask

   task automatic test_random_frames(input int unsigned n);
      int unsigned                goal, w, h, wmax;
      logic [GRID_COEF_W-1:0]     cx, cy;
      logic [hds_pkg::COEF_W-1:0] g;
      logic [hds_pkg::TEMP_W-1:0] b;
      goal = points_sent + n;
      while (points_sent < goal) begin
         wait_drained();
         wmax = ($urandom_range(9) == 0) ? 64 : 14;
         w = ($urandom_range(11) == 0) ? $urandom_range(2) : $urandom_range(wmax, 3);
         h = ($urandom_range(11) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
         cx = ($urandom_range(4) == 0) ? '1 : ($urandom_range(4) == 0) ? '0 : 16'($urandom());
         cy = ($urandom_range(4) == 0) ? '1 : ($urandom_range(4) == 0) ? '0 : 16'($urandom());
         g = ($urandom_range(4) == 0) ? '1 : ($urandom_range(4) == 0) ? '0 : 20'($urandom());
         b = ($urandom_range(5) == 0) ? hds_pkg::TEMP_MAX :
             ($urandom_range(5) == 0) ? hds_pkg::TEMP_MIN : $urandom();
         load_settings(w, h, cx, cy, g, b);
         run_frame(data_mix_type'($urandom_range(2)));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("unexpected word: temp_out %0d col_out %0d row_out %0d",
                   rsp_temp_out, rsp_col_out, rsp_row_out);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_temp_out !== want.temp) begin
               $error("temp_out: expected %0d, got %0d", want.temp, rsp_temp_out);
               mismatch_count++;
            end
            if (rsp_col_out !== want.col) begin
               $error("col_out: expected %0d, got %0d", want.col, rsp_col_out);
               mismatch_count++;
            end
            if (rsp_row_out !== want.row) begin
               $error("row_out: expected %0d, got %0d", want.row, rsp_row_out);
               mismatch_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0d, got %0d", want.last, rsp_frame_last);
               mismatch_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 76;
      test_rounding_ties();
      test_saturation();
      test_spare_index();
      test_size_clamp();
      test_random_frames(RANDOM_POINTS / 3);
      send_idle_pct = 76;
      recv_idle_pct = 19;
      test_random_frames(RANDOM_POINTS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(RANDOM_POINTS / 3);
      wait_drained();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
rtl/hds_pkg.sv
rtl/hds_mac_cell.sv
rtl/hds_window.sv
rtl/hds_out.sv
rtl/heat_diffusion_2d_stencil_step.sv
bench/heat_diffusion_2d_stencil_step_tb.sv
